// File: rtl/core/tcw_pkg.sv
// Shared constants, types and helpers of the text console writer.
package tcw_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int DISPLAY_CELLS  = 16384;
	localparam int CONSOLE_COUNT  = 4;

	localparam int SLICE_CELLS  = DISPLAY_CELLS / CONSOLE_COUNT;
	localparam int USABLE_CELLS = SLICE_CELLS - SCREEN_COLUMNS;
	localparam int SCREEN_CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

	// word field widths
	localparam int CON_FW    = 2;
	localparam int CHAR_W    = 8;
	localparam int RADDR_W   = 14;
	localparam int CURSOR_W  = 15;
	localparam int SCREEN_W  = 14;
	localparam int DATA_W    = 16;
	localparam int FIRST_W   = 12;

	// internal widths
	localparam int MAW = $clog2(DISPLAY_CELLS);
	localparam int PW  = MAW + 1;
	localparam int SW  = MAW;
	localparam int CIW = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;
	localparam int WCW = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;

	// row = (offset * DIV_M) >> DIV_K, exact for any PW-bit offset
	localparam int DIV_K  = PW + $clog2(SCREEN_COLUMNS) + 1;
	localparam int DIV_M  = ((1 << DIV_K) + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;
	localparam int DIV_MW = DIV_K - $clog2(SCREEN_COLUMNS) + 1;

	localparam logic [7:0]        TEXT_ATTR    = 8'h07;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

	typedef enum logic [1:0] {
		KIND_READ    = 2'd0,
		KIND_CHAR    = 2'd1,
		KIND_NEWLINE = 2'd2,
		KIND_NOP     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [CIW-1:0]      con;
		logic [CHAR_W-1:0]   ch;
		logic [RADDR_W-1:0]  addr;
	} item_t;

	typedef struct packed {
		logic               init0;
		logic [FIRST_W-1:0] first_cursor;
		logic [CON_FW-1:0]  active;
	} cfg_t;

	function automatic logic [PW-1:0] slice_start(input logic [CIW-1:0] idx);
		return PW'(SLICE_CELLS * int'(idx));
	endfunction

endpackage

// File: rtl/core/text_console_writer_core.sv
// Top level of the text console writer: APB registers, front queue and back end.
// Accept to result register: a character passes S_CHAR, S_CHK, S_RESULT; a newline
// S_ROW, S_NL, S_CHK, S_RESULT; a read S_RDATA, S_RESULT; an ignored word S_RESULT.
// A scroll of a full console adds a copy of (used cells - columns) cells and a row clear;
// copies go one cell a cycle through the RAM port. One word in the back end at a time.
// After reset the cell memory is swept to zero with item_stall high.
module text_console_writer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          op,
	input  logic [tcw_pkg::CON_FW-1:0]    console_index,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::RADDR_W-1:0]   read_address,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [tcw_pkg::CURSOR_W-1:0]  cursor_position,
	output logic [tcw_pkg::SCREEN_W-1:0]  screen_start,
	output logic [tcw_pkg::DATA_W-1:0]    read_data
);

	logic [tcw_pkg::CON_FW-1:0]  active_q;
	logic [tcw_pkg::FIRST_W-1:0] first_cursor_q;
	logic                        cfg_we;
	tcw_pkg::cfg_t               cfg;
	logic                        q_valid;
	tcw_pkg::item_t              q_item;
	logic                        q_pop;
	logic                        clearing;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = paddr[2] ? 32'(first_cursor_q) : 32'(active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= '0;
			first_cursor_q <= '0;
		end else if (cfg_we) begin
			if (paddr[2]) begin
				first_cursor_q <= pwdata[tcw_pkg::FIRST_W-1:0];
			end else begin
				active_q <= pwdata[tcw_pkg::CON_FW-1:0];
			end
		end
	end

	assign cfg.init0        = cfg_we && paddr[2];
	assign cfg.first_cursor = pwdata[tcw_pkg::FIRST_W-1:0];
	assign cfg.active       = active_q;

	tcw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.op            (op),
		.console_index (console_index),
		.char_code     (char_code),
		.read_address  (read_address),
		.hold          (clearing),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	tcw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.clearing        (clearing),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.cursor_position (cursor_position),
		.screen_start    (screen_start),
		.read_data       (read_data)
	);

endmodule

// File: rtl/core/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/tcw_front.sv
// Input side: accepts words, classifies them and queues them for the back end.
module tcw_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         op,
	input  logic [tcw_pkg::CON_FW-1:0]   console_index,
	input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcw_pkg::RADDR_W-1:0]  read_address,
	input  logic                         hold,
	output logic                         q_valid,
	output tcw_pkg::item_t               q_item,
	input  logic                         q_pop
);

	tcw_pkg::item_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	tcw_pkg::item_t cls;
	logic           push;

	always_comb begin
		cls.con  = tcw_pkg::CIW'(console_index);
		cls.ch   = char_code;
		cls.addr = read_address;
		priority if (op) begin
			cls.kind = tcw_pkg::KIND_READ;
		end else if (32'(console_index) >= 32'(tcw_pkg::CONSOLE_COUNT)) begin
			cls.kind = tcw_pkg::KIND_NOP;
		end else if (char_code == tcw_pkg::NEWLINE_CODE) begin
			cls.kind = tcw_pkg::KIND_NEWLINE;
		end else begin
			cls.kind = tcw_pkg::KIND_CHAR;
		end
	end

	assign item_stall = (count_q == 2'd2) || hold;
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != 2'd0);
	assign q_item     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// File: rtl/core/tcw_back.sv
// Back end: console state, cell memory, write/scroll sequencer and result register.
module tcw_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcw_pkg::cfg_t                  cfg,
	input  logic                           q_valid,
	input  tcw_pkg::item_t                 q_item,
	output logic                           q_pop,
	output logic                           clearing,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [tcw_pkg::CURSOR_W-1:0]   cursor_position,
	output logic [tcw_pkg::SCREEN_W-1:0]   screen_start,
	output logic [tcw_pkg::DATA_W-1:0]     read_data
);

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_ROW    = 10'b0000000100,
		S_NL     = 10'b0000001000,
		S_CHAR   = 10'b0000010000,
		S_CHK    = 10'b0000100000,
		S_COPY   = 10'b0001000000,
		S_WIPE   = 10'b0010000000,
		S_RDATA  = 10'b0100000000,
		S_RESULT = 10'b1000000000
	} state_t;

	localparam int PW  = tcw_pkg::PW;
	localparam int SW  = tcw_pkg::SW;
	localparam int MAW = tcw_pkg::MAW;
	localparam int CIW = tcw_pkg::CIW;
	localparam int PRW = PW + tcw_pkg::DIV_MW;

	state_t state_q;

	// per-console state
	logic [PW-1:0] cur_arr_q  [tcw_pkg::CONSOLE_COUNT];
	logic [SW-1:0] scr_arr_q  [tcw_pkg::CONSOLE_COUNT];
	logic          full_arr_q [tcw_pkg::CONSOLE_COUNT];

	// working copy of the console being served
	logic [CIW-1:0]             con_q;
	logic [tcw_pkg::CHAR_W-1:0] ch_q;
	logic [PW-1:0]              cur_q;
	logic [SW-1:0]              scr_q;
	logic                       full_q;
	logic [PW-1:0]              start_q;
	logic [PW-1:0]              row_q;
	logic [PW-1:0]              n_q;
	logic [PW-1:0]              cp_q;
	logic [tcw_pkg::WCW-1:0]    wipe_q;
	logic [MAW-1:0]             clr_q;
	logic [tcw_pkg::DATA_W-1:0] data_q;
	logic                       rd_ok_q;

	// copy write stage
	logic          pend_s1;
	logic [PW-1:0] pdst_s1;
	logic          psrc_ok_s1;

	logic                       res_valid_q;
	logic [tcw_pkg::CURSOR_W-1:0] res_cur_q;
	logic [tcw_pkg::SCREEN_W-1:0] res_scr_q;
	logic [tcw_pkg::DATA_W-1:0] res_data_q;

	logic                       mem_we;
	logic [MAW-1:0]             mem_waddr;
	logic [tcw_pkg::DATA_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [MAW-1:0]             mem_raddr;
	logic [tcw_pkg::DATA_W-1:0] mem_rdata;

	logic [CIW-1:0] cidx;
	logic [PW-1:0]  cur_rd;
	logic [SW-1:0]  scr_rd;
	logic           full_rd;
	logic           act_ok;
	logic           slot_free;

	logic [PW-1:0]  diff_w;
	logic [PRW-1:0] prod_w;
	logic [PW-1:0]  used_w;
	logic           hit_w;
	logic           full_n;
	logic           scroll_w;
	logic [PW:0]    src_w;
	logic [PW-1:0]  dst_w;
	logic [PW:0]    wipe_addr_w;
	logic           cp_more;

	assign cur_rd  = cur_arr_q[cidx];
	assign scr_rd  = scr_arr_q[cidx];
	assign full_rd = full_arr_q[cidx];
	assign act_ok  = 32'(cfg.active) < 32'(tcw_pkg::CONSOLE_COUNT);
	assign slot_free = !res_valid_q || !result_stall;
	assign clearing  = (state_q == S_CLEAR);

	always_comb begin
		diff_w   = (cur_q >= PW'(scr_q)) ? cur_q - PW'(scr_q) : '0;
		prod_w   = PRW'(diff_w) * PRW'(tcw_pkg::DIV_M);
		used_w   = (cur_q >= start_q) ? cur_q - start_q : '0;
		hit_w    = (tcw_pkg::USABLE_CELLS <= 0) || (int'(used_w) >= tcw_pkg::USABLE_CELLS);
		full_n   = full_q || hit_w;
		scroll_w = 32'(diff_w) >= 32'(tcw_pkg::SCREEN_CELLS);
		src_w    = (PW+1)'(start_q) + (PW+1)'(tcw_pkg::SCREEN_COLUMNS) + (PW+1)'(cp_q);
		dst_w    = start_q + cp_q;
		wipe_addr_w = (PW+1)'(cur_q) + (PW+1)'(wipe_q);
		cp_more  = cp_q < n_q;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		q_pop     = 1'b0;
		cidx      = q_item.con;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_IDLE: begin
				q_pop = q_valid;
				if (q_valid && q_item.kind == tcw_pkg::KIND_READ) begin
					mem_re    = 1'b1;
					mem_raddr = MAW'(q_item.addr);
				end
			end
			S_CHAR: begin
				if (32'(cur_q) < 32'(tcw_pkg::DISPLAY_CELLS)) begin
					mem_we    = 1'b1;
					mem_waddr = MAW'(cur_q);
					mem_wdata = {tcw_pkg::TEXT_ATTR, ch_q};
				end
			end
			S_COPY: begin
				if (cp_more) begin
					mem_re    = 1'b1;
					mem_raddr = MAW'(src_w);
				end
				if (pend_s1 && 32'(pdst_s1) < 32'(tcw_pkg::DISPLAY_CELLS)) begin
					mem_we    = 1'b1;
					mem_waddr = MAW'(pdst_s1);
					mem_wdata = psrc_ok_s1 ? mem_rdata : '0;
				end
			end
			S_WIPE: begin
				if (32'(wipe_addr_w) < 32'(tcw_pkg::DISPLAY_CELLS)) begin
					mem_we    = 1'b1;
					mem_waddr = MAW'(wipe_addr_w);
				end
			end
			S_RESULT: begin
				cidx = CIW'(cfg.active);
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH (tcw_pkg::DATA_W),
		.DEPTH (tcw_pkg::DISPLAY_CELLS)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		pdst_s1    <= dst_w;
		psrc_ok_s1 <= 32'(src_w) < 32'(tcw_pkg::DISPLAY_CELLS);
		if (state_q == S_RESULT && slot_free) begin
			res_cur_q  <= act_ok ? tcw_pkg::CURSOR_W'(cur_rd) : '0;
			res_scr_q  <= act_ok ? tcw_pkg::SCREEN_W'(scr_rd) : '0;
			res_data_q <= data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
			con_q       <= '0;
			ch_q        <= '0;
			cur_q       <= '0;
			scr_q       <= '0;
			full_q      <= 1'b0;
			start_q     <= '0;
			row_q       <= '0;
			n_q         <= '0;
			cp_q        <= '0;
			wipe_q      <= '0;
			data_q      <= '0;
			rd_ok_q     <= 1'b0;
			for (int i = 0; i < tcw_pkg::CONSOLE_COUNT; i++) begin
				cur_arr_q[i]  <= PW'(tcw_pkg::SLICE_CELLS * i);
				scr_arr_q[i]  <= SW'(tcw_pkg::SLICE_CELLS * i);
				full_arr_q[i] <= 1'b0;
			end
		end else begin
			pend_s1 <= 1'b0;
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.init0) begin
				cur_arr_q[0]  <= PW'(cfg.first_cursor);
				scr_arr_q[0]  <= '0;
				full_arr_q[0] <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAW'(tcw_pkg::DISPLAY_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						con_q   <= q_item.con;
						ch_q    <= q_item.ch;
						cur_q   <= cur_rd;
						scr_q   <= scr_rd;
						full_q  <= full_rd;
						start_q <= tcw_pkg::slice_start(q_item.con);
						data_q  <= '0;
						rd_ok_q <= 32'(q_item.addr) < 32'(tcw_pkg::DISPLAY_CELLS);
						unique case (q_item.kind)
							tcw_pkg::KIND_READ:    state_q <= S_RDATA;
							tcw_pkg::KIND_CHAR:    state_q <= S_CHAR;
							tcw_pkg::KIND_NEWLINE: state_q <= S_ROW;
							tcw_pkg::KIND_NOP:     state_q <= S_RESULT;
							default:               state_q <= S_RESULT;
						endcase
					end
				end
				S_ROW: begin
					row_q   <= PW'(prod_w >> tcw_pkg::DIV_K);
					state_q <= S_NL;
				end
				S_NL: begin
					cur_q <= PW'(scr_q) + PW'((32'(row_q) + 32'd1)
						* 32'(tcw_pkg::SCREEN_COLUMNS));
					state_q <= S_CHK;
				end
				S_CHAR: begin
					cur_q   <= cur_q + 1'b1;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (scroll_w && full_n) begin
						n_q     <= (32'(used_w) > 32'(tcw_pkg::SCREEN_COLUMNS))
							? used_w - PW'(tcw_pkg::SCREEN_COLUMNS) : '0;
						cp_q    <= '0;
						full_q  <= 1'b1;
						state_q <= S_COPY;
					end else begin
						cur_arr_q[con_q]  <= cur_q;
						scr_arr_q[con_q]  <= scroll_w
							? SW'(scr_q + SW'(tcw_pkg::SCREEN_COLUMNS)) : scr_q;
						full_arr_q[con_q] <= full_n;
						state_q <= S_RESULT;
					end
				end
				S_COPY: begin
					if (cp_more) begin
						pend_s1 <= 1'b1;
						cp_q    <= cp_q + 1'b1;
					end else if (!pend_s1) begin
						cur_q   <= cur_q - PW'(tcw_pkg::SCREEN_COLUMNS);
						wipe_q  <= '0;
						state_q <= S_WIPE;
					end
				end
				S_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
					if (32'(wipe_q) == 32'(tcw_pkg::SCREEN_COLUMNS - 1)) begin
						cur_arr_q[con_q]  <= cur_q;
						scr_arr_q[con_q]  <= scr_q;
						full_arr_q[con_q] <= 1'b1;
						state_q <= S_RESULT;
					end
				end
				S_RDATA: begin
					data_q  <= rd_ok_q ? mem_rdata : '0;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid    = res_valid_q;
	assign cursor_position = res_cur_q;
	assign screen_start    = res_scr_q;
	assign read_data       = res_data_q;

	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && q_valid) |=> (state_q != S_IDLE))
		else $error("queued word not taken up");

	a_copy_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> full_q)
		else $error("scroll copy on a console that is not full");

	a_pend_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_COPY))
		else $error("copy write outside the copy phase");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && slot_free) |=> (res_valid_q && state_q == S_IDLE))
		else $error("result not loaded");

endmodule
